FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SLM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// implication checked at the same clock edge
`define SLM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Field widths and request codes of the sorted list merge block
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int OUT_USER_W = 2;

    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [VALUE_W-1:0] t_value;

    localparam t_mode MODE_LOAD_FIRST  = 2'd0;
    localparam t_mode MODE_LOAD_SECOND = 2'd1;
    localparam t_mode MODE_MERGE       = 2'd2;

    // positions in the result tuser
    localparam int USER_FROM_SECOND = 0;
    localparam int USER_OVERFLOW    = 1;

endpackage

FILE: src/slm_ram.sv
// ----------------------------------------------------------------------------
// slm_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module slm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sorted_list_merge.sv
// ----------------------------------------------------------------------------
// sorted_list_merge
// Two-way stable merge of two sorted lists of signed 32-bit values
// ----------------------------------------------------------------------------
// Requests with tuser 0 or 1 append tdata to the first or second list; a load
// into a full list is dropped and flagged on every result of the next merge.
// A request with tuser 2 merges both lists in ascending signed order, first
// list first on ties, and empties them. The merge runs through one shared
// compare under a small sequencer and handles each element in a fetch step
// for the list RAM reads and then an emit step for compare and emit; the emit
// step waits while the output register holds a result not yet taken. A merge
// of two empty lists emits no result. The input is not ready while a merge
// runs. Results leave through an output register, so the last result may
// wait while new loads are taken. Request code 3 is accepted and ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_merge
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    input  logic [MODE_W-1:0]     s_axis_tuser,   // [1:0] mode
    // result side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [31:0] merged_value
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] from_second, [1] overflow
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_idx_a, n_idx_a;
    logic [CW-1:0] r_idx_b, n_idx_b;
    logic          r_dropped, n_dropped;

    logic          r_out_valid, n_out_valid;
    t_value        r_out_value, n_out_value;
    logic          r_out_src, n_out_src;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          w_accept;
    t_mode         w_mode;
    logic          w_we_a, w_we_b;
    logic          w_full_a, w_full_b;
    t_value        w_rd_a, w_rd_b;
    logic          w_take_a;
    logic          w_out_free;
    logic [CW:0]   w_total;
    logic [CW:0]   w_done_next;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser;
    assign w_full_a      = (r_cnt_a >= CW'(LIST_DEPTH));
    assign w_full_b      = (r_cnt_b >= CW'(LIST_DEPTH));
    assign w_we_a        = w_accept && (w_mode == MODE_LOAD_FIRST) && !w_full_a;
    assign w_we_b        = w_accept && (w_mode == MODE_LOAD_SECOND) && !w_full_b;

    slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_idx_a[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_idx_b[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    // shared compare: first list wins on ties
    assign w_take_a = (r_idx_a < r_cnt_a) &&
                      ((r_idx_b >= r_cnt_b) || ($signed(w_rd_a) <= $signed(w_rd_b)));
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_total     = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign w_done_next = {1'b0, r_idx_a} + {1'b0, r_idx_b} + (CW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_src   = r_out_src;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_mode)
                        MODE_LOAD_FIRST: begin
                            if (w_full_a) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                        end
                        MODE_LOAD_SECOND: begin
                            if (w_full_b) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_cnt_b = r_cnt_b + CW'(1);
                            end
                        end
                        MODE_MERGE: begin
                            n_idx_a = '0;
                            n_idx_b = '0;
                            if (w_total == '0) begin
                                n_dropped = 1'b0;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_take_a ? w_rd_a : w_rd_b;
                    n_out_src   = !w_take_a;
                    n_out_last  = (w_done_next == w_total);
                    n_out_ovf   = r_dropped;
                    if (w_take_a) begin
                        n_idx_a = r_idx_a + CW'(1);
                    end else begin
                        n_idx_b = r_idx_b + CW'(1);
                    end
                    if (w_done_next == w_total) begin
                        n_state   = S_IDLE;
                        n_cnt_a   = '0;
                        n_cnt_b   = '0;
                        n_idx_a   = '0;
                        n_idx_b   = '0;
                        n_dropped = 1'b0;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_idx_a     <= '0;
            r_idx_b     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_idx_a     <= n_idx_a;
            r_idx_b     <= n_idx_b;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_src   <= n_out_src;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign m_axis_tvalid                  = r_out_valid;
    assign m_axis_tdata                   = r_out_value;
    assign m_axis_tuser[USER_FROM_SECOND] = r_out_src;
    assign m_axis_tuser[USER_OVERFLOW]    = r_out_ovf;
    assign m_axis_tlast                   = r_out_last;

    // read pointers never pass the fill counts
    `SLM_ASSERT(a_idx_in_range, (r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b), "merge index past count")
    // fill counts stay within the list depth
    `SLM_ASSERT(a_cnt_in_range, (r_cnt_a <= CW'(LIST_DEPTH)) && (r_cnt_b <= CW'(LIST_DEPTH)), "list count past depth")
    // an emit step always has an element left to take
    `SLM_ASSERT_IMP(a_emit_has_data, r_state == S_EMIT, (r_idx_a < r_cnt_a) || (r_idx_b < r_cnt_b), "emit with both lists drained")
    // outside a merge both read pointers rest at zero
    `SLM_ASSERT_IMP(a_idle_idx_zero, r_state == S_IDLE, (r_idx_a == '0) && (r_idx_b == '0), "stale merge index while idle")

endmodule
